FILE: design/gtc_pkg.sv
// Shared types, constants and helper functions for the grayscale tint colorizer.
// Used by gray_tint_colorize_pixel; no dependencies.
package gtc_pkg;

	typedef logic [7:0] chan_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TINT_RED   = 2'd0,
		REG_TINT_GREEN = 2'd1,
		REG_TINT_BLUE  = 2'd2,
		REG_TINT_ALPHA = 2'd3
	} cfg_reg_t;

	localparam int unsigned ChanW    = 8;
	localparam int unsigned NumCol   = 3;
	localparam int unsigned GrayMulR = 11;
	localparam int unsigned GrayMulG = 16;
	localparam int unsigned GrayMulB = 5;
	localparam int unsigned GraySumW = 13;
	localparam int unsigned RampW    = 15;
	localparam int unsigned BlendW   = 16;
	localparam int unsigned RampDiv  = 127;
	localparam int unsigned Full     = 255;

	// n / 127 for n <= 127*255: n = 128*q0 + lo, so n = 127*q0 + (lo + q0)
	function automatic chan_t div127(input logic [RampW-1:0] n);
		chan_t      q;
		logic [8:0] r;
		q = n[14:7];
		r = 9'(n[6:0]) + 9'(q);
		if (r >= 9'(2 * RampDiv)) begin
			q = q + 8'd2;
		end else if (r >= 9'(RampDiv)) begin
			q = q + 8'd1;
		end
		return q;
	endfunction

	// n / 255 for n <= 255*255
	function automatic chan_t div255(input logic [BlendW-1:0] n);
		chan_t      q;
		logic [8:0] r;
		q = n[15:8];
		r = 9'(n[7:0]) + 9'(q);
		if (r >= 9'(Full)) begin
			q = q + 8'd1;
		end
		return q;
	endfunction

endpackage

FILE: design/gray_tint_colorize_pixel.sv
// Grayscale tint colorizer, one ARGB8888 pixel per transaction.
// Five register stages (s1 to s5); out_valid is the valid bit of the last one. Throughput one
// pixel per cycle, the whole pipeline holding while the output is stalled.
// Reset (arst_n, asynchronous, active low) empties the pipeline and clears
// all tint registers to zero. Depends on gtc_pkg.
module gray_tint_colorize_pixel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  gtc_pkg::chan_t      cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  gtc_pkg::chan_t      src_red,
	input  gtc_pkg::chan_t      src_green,
	input  gtc_pkg::chan_t      src_blue,
	input  gtc_pkg::chan_t      src_alpha,
	output logic                out_valid,
	input  logic                out_stall,
	output gtc_pkg::chan_t      out_red,
	output gtc_pkg::chan_t      out_green,
	output gtc_pkg::chan_t      out_blue,
	output gtc_pkg::chan_t      out_alpha
);

	gtc_pkg::chan_t tint_q [gtc_pkg::NumCol];
	gtc_pkg::chan_t tint_alpha_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	gtc_pkg::chan_t                   src_s1 [gtc_pkg::NumCol];
	gtc_pkg::chan_t                   src_s2 [gtc_pkg::NumCol];
	gtc_pkg::chan_t                   src_s3 [gtc_pkg::NumCol];
	gtc_pkg::chan_t                   alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5;
	gtc_pkg::chan_t                   gray_s1;
	logic [gtc_pkg::RampW-1:0]        num_s2 [gtc_pkg::NumCol];
	gtc_pkg::chan_t                   ramp_s3 [gtc_pkg::NumCol];
	logic [gtc_pkg::BlendW-1:0]       bl_s4 [gtc_pkg::NumCol];
	gtc_pkg::chan_t                   res_s5 [gtc_pkg::NumCol];

	logic [gtc_pkg::GraySumW-1:0]     gray_sum;
	logic [gtc_pkg::RampW-1:0]        num_d [gtc_pkg::NumCol];
	logic [gtc_pkg::BlendW-1:0]       bl_d [gtc_pkg::NumCol];

	assign adv      = !(v_s5 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gtc_pkg::NumCol; i++) begin
				tint_q[i] <= '0;
			end
			tint_alpha_q <= '0;
		end else if (cfg_we) begin
			unique case (gtc_pkg::cfg_reg_t'(cfg_index))
				gtc_pkg::REG_TINT_RED:   tint_q[0]    <= cfg_data;
				gtc_pkg::REG_TINT_GREEN: tint_q[1]    <= cfg_data;
				gtc_pkg::REG_TINT_BLUE:  tint_q[2]    <= cfg_data;
				gtc_pkg::REG_TINT_ALPHA: tint_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [gtc_pkg::GraySumW-1:0] gray_tint_sum(
		input gtc_pkg::chan_t r,
		input gtc_pkg::chan_t g,
		input gtc_pkg::chan_t b
	);
		return gtc_pkg::GraySumW'(r * gtc_pkg::GrayMulR)
			+ gtc_pkg::GraySumW'(g * gtc_pkg::GrayMulG)
			+ gtc_pkg::GraySumW'(b * gtc_pkg::GrayMulB);
	endfunction

	// luma: (11R + 16G + 5B) / 32
	assign gray_sum = gray_tint_sum(src_red, src_green, src_blue);

	// ramp numerator: low half gray*t, high half (gray-128)*(255-t) + 127*t
	always_comb begin
		for (int i = 0; i < gtc_pkg::NumCol; i++) begin
			num_d[i] = gtc_pkg::RampW'(gray_s1[6:0]
				* (gray_s1[7] ? gtc_pkg::Full - tint_q[i] : tint_q[i]));
			if (gray_s1[7]) begin
				num_d[i] = num_d[i] + gtc_pkg::RampW'(tint_q[i] * gtc_pkg::RampDiv);
			end
		end
	end

	// blend: a*c + (255-a)*src
	always_comb begin
		for (int i = 0; i < gtc_pkg::NumCol; i++) begin
			bl_d[i] = gtc_pkg::BlendW'(tint_alpha_q * ramp_s3[i])
				+ gtc_pkg::BlendW'((gtc_pkg::Full - tint_alpha_q) * src_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1[0] <= src_red;
			src_s1[1] <= src_green;
			src_s1[2] <= src_blue;
			alpha_s1  <= src_alpha;
			gray_s1   <= gray_sum[12:5];
			src_s2    <= src_s1;
			alpha_s2  <= alpha_s1;
			src_s3    <= src_s2;
			alpha_s3  <= alpha_s2;
			alpha_s4  <= alpha_s3;
			alpha_s5  <= alpha_s4;
			for (int i = 0; i < gtc_pkg::NumCol; i++) begin
				num_s2[i]  <= num_d[i];
				ramp_s3[i] <= gtc_pkg::div127(num_s2[i]);
				bl_s4[i]   <= bl_d[i];
				res_s5[i]  <= gtc_pkg::div255(bl_s4[i]);
			end
		end
	end

	assign out_valid = v_s5;
	assign out_red   = res_s5[0];
	assign out_green = res_s5[1];
	assign out_blue  = res_s5[2];
	assign out_alpha = alpha_s5;

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transaction did not enter the pipeline");

	a_ramp_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (num_s2[0] <= 15'(gtc_pkg::RampDiv * gtc_pkg::Full))
			&& (num_s2[1] <= 15'(gtc_pkg::RampDiv * gtc_pkg::Full))
			&& (num_s2[2] <= 15'(gtc_pkg::RampDiv * gtc_pkg::Full)))
		else $error("ramp numerator out of range");

	a_blend_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (bl_s4[0] <= 16'(gtc_pkg::Full * gtc_pkg::Full))
			&& (bl_s4[1] <= 16'(gtc_pkg::Full * gtc_pkg::Full))
			&& (bl_s4[2] <= 16'(gtc_pkg::Full * gtc_pkg::Full)))
		else $error("blend sum out of range");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s3) && $stable(v_s4) && $stable(alpha_s4))
		else $error("pipeline moved while stalled");
`endif

endmodule

FILE: verif/tb_gray_tint_colorize_pixel.sv
`timescale 1ns / 100ps
// Self-checking testbench for gray_tint_colorize_pixel: random and directed pixels under
// several tint settings, with idling on both channels and a scoreboard predicting each result.
// Depends on gtc_pkg and the gray_tint_colorize_pixel RTL.
module tb_gray_tint_colorize_pixel;

	typedef struct packed {
		gtc_pkg::chan_t red;
		gtc_pkg::chan_t green;
		gtc_pkg::chan_t blue;
		gtc_pkg::chan_t alpha;
	} pixel_t;

	class colorize_scoreboard;
		gtc_pkg::chan_t tint_red;
		gtc_pkg::chan_t tint_green;
		gtc_pkg::chan_t tint_blue;
		gtc_pkg::chan_t tint_alpha;
		pixel_t         colorized_q[$];
		int             failures;

		function new();
			tint_red   = '0;
			tint_green = '0;
			tint_blue  = '0;
			tint_alpha = '0;
			failures   = 0;
		endfunction

		function void set_tint(gtc_pkg::cfg_reg_t idx, gtc_pkg::chan_t value);
			case (idx)
				gtc_pkg::REG_TINT_RED:   tint_red   = value;
				gtc_pkg::REG_TINT_GREEN: tint_green = value;
				gtc_pkg::REG_TINT_BLUE:  tint_blue  = value;
				gtc_pkg::REG_TINT_ALPHA: tint_alpha = value;
				default: ;
			endcase
		endfunction

		// two-segment ramp through the tint value at mid grey
		function int unsigned ramp_level(int unsigned luma, int unsigned tint);
			if (luma < 128) begin
				return (luma * tint) / 127;
			end
			return ((luma - 128) * (255 - tint) + 127 * tint) / 127;
		endfunction

		function gtc_pkg::chan_t mix(int unsigned level, int unsigned src,
			int unsigned strength);
			return gtc_pkg::chan_t'((strength * level + (255 - strength) * src) / 255);
		endfunction

		function pixel_t colorize(pixel_t src);
			int unsigned luma;
			pixel_t      res;
			luma = (11 * int'(src.red) + 16 * int'(src.green) + 5 * int'(src.blue)) / 32;
			res.red   = mix(ramp_level(luma, tint_red), src.red, tint_alpha);
			res.green = mix(ramp_level(luma, tint_green), src.green, tint_alpha);
			res.blue  = mix(ramp_level(luma, tint_blue), src.blue, tint_alpha);
			res.alpha = src.alpha;
			return res;
		endfunction

		function void note_source(pixel_t src);
			colorized_q.push_back(colorize(src));
		endfunction

		function void check_output(pixel_t seen);
			pixel_t want;
			if (colorized_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d", $realtime,
						seen.red, seen.green, seen.blue, seen.alpha);
				return;
			end
			want = colorized_q.pop_front();
			if (seen != want) begin
				failures++;
				if (failures <= 10)
					$display("%0t: mismatch exp r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
						$realtime, want.red, want.green, want.blue, want.alpha,
						seen.red, seen.green, seen.blue, seen.alpha);
			end
		endfunction

		function int pending();
			return colorized_q.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic  [1:0]    cfg_index;
	gtc_pkg::chan_t cfg_data;
	logic           in_valid;
	logic           in_stall;
	gtc_pkg::chan_t src_red;
	gtc_pkg::chan_t src_green;
	gtc_pkg::chan_t src_blue;
	gtc_pkg::chan_t src_alpha;
	logic           out_valid;
	logic           out_stall;
	gtc_pkg::chan_t out_red;
	gtc_pkg::chan_t out_green;
	gtc_pkg::chan_t out_blue;
	gtc_pkg::chan_t out_alpha;
	bit             calm;

	colorize_scoreboard board = new();

	gray_tint_colorize_pixel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_red   (src_red),
		.src_green (src_green),
		.src_blue  (src_blue),
		.src_alpha (src_alpha),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// output back-pressure: short bursts mostly, occasionally long ones
	initial begin
		int unsigned run;
		int unsigned hold;
		out_stall = 1'b0;
		forever begin
			if (calm) begin
				@(negedge clk) out_stall <= 1'b0;
			end else begin
				run  = $urandom_range(0, 20);
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				repeat (run) @(negedge clk) out_stall <= 1'b0;
				repeat (hold) @(negedge clk) out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_output(pixel_t'({out_red, out_green, out_blue, out_alpha}));
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic gtc_pkg::chan_t pick_level();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return gtc_pkg::chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t random_source();
		pixel_t      px;
		int unsigned v;
		px = pixel_t'($urandom);
		case ($urandom_range(0, 9))
			0, 1: begin
				// grey around the ramp knee
				v = $urandom_range(124, 131);
				px.red   = gtc_pkg::chan_t'(v);
				px.green = gtc_pkg::chan_t'(v);
				px.blue  = gtc_pkg::chan_t'(v);
			end
			2: begin
				px.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				px.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic write_tint(input gtc_pkg::cfg_reg_t idx, input gtc_pkg::chan_t value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		board.set_tint(idx, value);
	endtask

	task automatic set_tints(input gtc_pkg::chan_t r, input gtc_pkg::chan_t g,
		input gtc_pkg::chan_t b, input gtc_pkg::chan_t a);
		write_tint(gtc_pkg::REG_TINT_RED, r);
		write_tint(gtc_pkg::REG_TINT_GREEN, g);
		write_tint(gtc_pkg::REG_TINT_BLUE, b);
		write_tint(gtc_pkg::REG_TINT_ALPHA, a);
	endtask

	task automatic send_pixel(input pixel_t px, input int unsigned gap);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		src_red   <= px.red;
		src_green <= px.green;
		src_blue  <= px.blue;
		src_alpha <= px.alpha;
		do @(posedge clk); while (in_stall);
		board.note_source(px);
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic run_corners();
		pixel_t corners [12];
		corners = '{
			'{8'd0,   8'd0,   8'd0,   8'd0},
			'{8'd255, 8'd255, 8'd255, 8'd255},
			'{8'd255, 8'd0,   8'd0,   8'd255},
			'{8'd0,   8'd255, 8'd0,   8'd128},
			'{8'd0,   8'd0,   8'd255, 8'd1},
			'{8'd127, 8'd127, 8'd127, 8'd0},
			'{8'd128, 8'd128, 8'd128, 8'd255},
			'{8'd126, 8'd127, 8'd130, 8'd77},
			'{8'd129, 8'd128, 8'd127, 8'd200},
			'{8'hAA,  8'h55,  8'hAA,  8'h55},
			'{8'h55,  8'hAA,  8'h55,  8'hAA},
			'{8'd1,   8'd254, 8'd1,   8'd254}
		};
		foreach (corners[k])
			send_pixel(corners[k], pick_gap());
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		src_red   = '0;
		src_green = '0;
		src_blue  = '0;
		src_alpha = '0;
		calm      = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset tint: alpha zero leaves the source untouched
		run_corners();
		set_tints(8'd255, 8'd0, 8'd128, 8'd255);
		run_corners();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: set_tints(8'd255, 8'd255, 8'd255, 8'd255);
				1: set_tints(8'd0, 8'd0, 8'd0, 8'd255);
				2: set_tints(8'd255, 8'd0, 8'd255, 8'd0);
				3: set_tints(8'd1, 8'd254, 8'd127, 8'd1);
				default: set_tints(pick_level(), pick_level(), pick_level(), pick_level());
			endcase
			calm = (phase == 2 || phase == 6);
			repeat (125)
				send_pixel(random_source(), pick_gap());
			drain();
			calm = 1'b0;
		end

		repeat (20) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
